>>> src/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_assert.svh
// assertion macros used by the sorted priority queue datapath
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication checked on every clock edge outside reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue controller and datapath
// ----------------------------------------------------------------------------
package spq_pkg;

    // item operation
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_INS_SHIFT = 3'd2;
    localparam logic [2:0] OP_INS_PLACE = 3'd3;
    localparam logic [2:0] OP_DEL_FIRST = 3'd4;
    localparam logic [2:0] OP_DEL_SHIFT = 3'd5;

    typedef struct packed {
        logic [7:0]         prio;
        logic signed [31:0] data;
    } t_entry;

    typedef struct packed {
        logic [2:0] op;
        logic       emit;
        logic [1:0] status;
        logic       dec;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic count_full;
        logic ptr_one;
        logic shift;
        logic del_last;
    } t_dp_sts;

endpackage

>>> src/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer for insert and remove, drives datapath operations
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_cmd,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_dp_cmd,
    output logic    o_busy
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_CMP   = 3'd1;
    localparam logic [2:0] S_INS_PLACE = 3'd2;
    localparam logic [2:0] S_DEL_FIRST = 3'd3;
    localparam logic [2:0] S_DEL_SHIFT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state      = r_state;
        w_cmd.op     = OP_NONE;
        w_cmd.emit   = 1'b0;
        w_cmd.status = ST_DONE;
        w_cmd.dec    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.op = OP_LOAD;
                    if (i_cmd == CMD_INSERT) begin
                        if (i_sts.count_full) begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.status = ST_FULL;
                        end else if (i_sts.count_zero) begin
                            n_state = S_INS_PLACE;
                        end else begin
                            n_state = S_INS_CMP;
                        end
                    end else begin
                        if (i_sts.count_zero) begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.status = ST_EMPTY;
                        end else begin
                            n_state = S_DEL_FIRST;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                if (i_sts.shift) begin
                    w_cmd.op = OP_INS_SHIFT;
                    if (i_sts.ptr_one) begin
                        n_state = S_INS_PLACE;
                    end
                end else begin
                    w_cmd.op   = OP_INS_PLACE;
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_INS_PLACE: begin
                w_cmd.op   = OP_INS_PLACE;
                w_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_DEL_FIRST: begin
                w_cmd.op = OP_DEL_FIRST;
                if (i_sts.count_one) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.dec  = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT: begin
                w_cmd.op = OP_DEL_SHIFT;
                if (i_sts.del_last) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.dec  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_dp_cmd = w_cmd;
    assign o_busy   = (r_state != S_IDLE);

endmodule

>>> src/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// entry store, pointer and count registers, result registers
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_dp_cmd,
    input  logic               i_cmd,
    input  logic signed [31:0] i_item_data,
    input  logic [7:0]         i_item_priority,
    output t_dp_sts            o_sts,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_data,
    output logic [7:0]         o_out_priority,
    output logic [4:0]         o_occupancy
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam logic [CNTW-1:0] ONE = CNTW'(1);
    localparam logic [CNTW-1:0] TWO = CNTW'(2);

    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    n_count;
    logic [CNTW-1:0]    r_ptr;
    logic [CNTW-1:0]    n_ptr;
    logic               r_valid;
    logic [1:0]         r_status;
    t_entry             r_item;
    t_entry             n_item;
    logic signed [31:0] r_out_data;
    logic signed [31:0] n_out_data;
    logic [7:0]         r_out_prio;
    logic [7:0]         n_out_prio;

    logic               w_we;
    logic [IDXW-1:0]    w_waddr;
    t_entry             w_wdata;
    logic [IDXW-1:0]    w_raddr;
    t_entry             w_rdata;

    spq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_item     = r_item;
        n_out_data = r_out_data;
        n_out_prio = r_out_prio;
        w_we       = 1'b0;
        w_waddr    = r_ptr[IDXW-1:0];
        w_wdata    = w_rdata;
        w_raddr    = '0;
        case (i_dp_cmd.op)
            OP_LOAD: begin
                n_item.data = i_item_data;
                n_item.prio = i_item_priority;
                n_out_data  = '0;
                n_out_prio  = '0;
                if (i_cmd == CMD_INSERT) begin
                    n_ptr   = r_count;
                    w_raddr = IDXW'(r_count - ONE);
                end else begin
                    n_ptr = '0;
                end
            end
            OP_INS_SHIFT: begin
                // move entry up one slot, fetch the one below
                w_we    = 1'b1;
                n_ptr   = r_ptr - ONE;
                w_raddr = IDXW'(r_ptr - TWO);
            end
            OP_INS_PLACE: begin
                w_we    = 1'b1;
                w_wdata = r_item;
                n_count = r_count + ONE;
            end
            OP_DEL_FIRST: begin
                n_out_data = w_rdata.data;
                n_out_prio = w_rdata.prio;
                n_ptr      = ONE;
                w_raddr    = IDXW'(ONE);
            end
            OP_DEL_SHIFT: begin
                // move entry down one slot, fetch the next one
                w_we    = 1'b1;
                w_waddr = IDXW'(r_ptr - ONE);
                n_ptr   = r_ptr + ONE;
                w_raddr = IDXW'(r_ptr + ONE);
            end
            default: begin
            end
        endcase
        if (i_dp_cmd.dec) begin
            n_count = r_count - ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_dp_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_item     <= n_item;
        r_out_data <= n_out_data;
        r_out_prio <= n_out_prio;
        if (i_dp_cmd.emit) begin
            r_status <= i_dp_cmd.status;
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_one  = (r_count == ONE);
    assign o_sts.count_full = (r_count == CNTW'(CAPACITY));
    assign o_sts.ptr_one    = (r_ptr == ONE);
    assign o_sts.shift      = (w_rdata.prio > r_item.prio);
    assign o_sts.del_last   = ((r_ptr + ONE) == r_count);

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_data     = r_out_data;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = 5'(r_count);

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNTW'(CAPACITY))
    `SPQ_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, r_valid && (r_status == ST_EMPTY), r_count == '0)
    `SPQ_ASSERT_IMP(a_count_moves, i_clk, i_rst_n, !$stable(r_count), r_valid)

endmodule

>>> src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept sorted by priority, lowest value served first
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a rising edge with start high and busy low. i_cmd
//   selects insert (data and priority placed in sorted order, after every
//   entry of equal or lower priority) or remove (front entry returned).
//   each item gives exactly one result, shown for one cycle with o_valid
//   high: o_status, o_out_data, o_out_priority and o_occupancy. the
//   receiver cannot stall, so a result is taken in the cycle it is shown.
// sequencing
//   entries sit in one ram with a registered read port. an insert walks
//   from the tail towards its slot, moving one entry a cycle. a remove
//   shifts every remaining entry down one slot. refused inserts and
//   removes from an empty queue give their result straight from idle.
//   busy is high while an item is being worked on; a new item may be
//   given in the cycle its predecessor's result is shown.
// reset
//   synchronous, active low; empties the queue. ram contents are left alone
//   since data read from slots at or above the count is never used.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_cmd,
    input  logic signed [31:0] i_item_data,
    input  logic [7:0]         i_item_priority,
    output logic               busy,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_data,
    output logic [7:0]         o_out_priority,
    output logic [4:0]         o_occupancy
);

    // command from the sequencer, status back from the datapath
    t_dp_cmd w_dp_cmd;
    t_dp_sts w_sts;

    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_sts    (w_sts),
        .o_dp_cmd (w_dp_cmd),
        .o_busy   (busy)
    );

    // entry store plus pointer, count and result registers
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (w_dp_cmd),
        .i_cmd           (i_cmd),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_data      (o_out_data),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

endmodule

>>> sim/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// self-checking bench for the sorted priority queue: a cycle-free model of
// the sorted store predicts every result as items are taken, and each
// strobed result is compared field by field with the oldest prediction.
// directed items cover empty and full queues, field extremes and equal
// priorities; random traffic then swings the queue between empty and full.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    // slowest item walks or shifts every entry once
    localparam int SETTLE_TICKS = QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 200000;

    // priority spreads for random inserts
    localparam int PRIO_NARROW   = 0;   // heavy ties
    localparam int PRIO_FULL     = 1;
    localparam int PRIO_EXTREME  = 2;
    localparam int PRIO_BAND     = 3;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [7:0]         prio;
        logic [4:0]         occupancy;
    } t_queue_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               i_cmd = CMD_INSERT;
    logic signed [31:0] i_item_data = '0;
    logic [7:0]         i_item_priority = '0;
    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_out_data;
    logic [7:0]         o_out_priority;
    logic [4:0]         o_occupancy;

    // model of the sorted store, front at index 0
    t_entry        sorted_store [QUEUE_DEPTH];
    int unsigned   held_count = 0;

    t_queue_result awaited_results [$];
    t_queue_result oldest_result;
    int            mismatch_count = 0;
    int unsigned   cycle_count = 0;
    bit            gaps_on = 1'b1;

    sorted_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_cmd           (i_cmd),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_data      (o_out_data),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // queue model
    // ------------------------------------------------------------------

    // applies one item to the model store and gives the result it owes
    function automatic t_queue_result apply_queue_op(logic cmd, logic signed [31:0] data,
                                                     logic [7:0] prio);
        t_queue_result res;
        int unsigned   slot;
        int unsigned   idx;
        res = '0;
        if (cmd == CMD_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                // refused, store untouched
                res.status = ST_FULL;
            end else begin
                // new entry goes after every entry of equal or lower priority
                slot = 0;
                while (slot < held_count && sorted_store[slot].prio <= prio)
                    slot++;
                for (idx = held_count; idx > slot; idx--)
                    sorted_store[idx] = sorted_store[idx - 1];
                sorted_store[slot].prio = prio;
                sorted_store[slot].data = data;
                held_count++;
                res.status = ST_DONE;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_DONE;
                res.data   = sorted_store[0].data;
                res.prio   = sorted_store[0].prio;
                for (idx = 1; idx < held_count; idx++)
                    sorted_store[idx - 1] = sorted_store[idx];
                held_count--;
            end
        end
        res.occupancy = 5'(held_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checking and prediction, both on the sampled edge
    // ------------------------------------------------------------------

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // a result shown this cycle belongs to an item taken earlier
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, status %0h data %0h",
                             $time, o_status, o_out_data);
                    mismatch_count++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    compare_field("status", oldest_result.status, o_status);
                    compare_field("out_data", oldest_result.data, o_out_data);
                    compare_field("out_priority", oldest_result.prio, o_out_priority);
                    compare_field("occupancy", oldest_result.occupancy, o_occupancy);
                end
            end
            // item taken at this edge
            if (start && !busy)
                awaited_results.push_back(apply_queue_op(i_cmd, i_item_data, i_item_priority));
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timed out with %0d results outstanding", $time,
                     awaited_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_priority(int spread);
        case (spread)
            PRIO_NARROW:  return 8'($urandom_range(0, 3));
            PRIO_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PRIO_BAND:    return 8'($urandom_range(120, 135));
            default:      return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // drives one item from a rising edge and holds it until taken,
    // then optionally lets the line go quiet for a while
    task automatic send_item(logic cmd, logic [31:0] data, logic [7:0] prio);
        int gap;
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_item_data     <= data;
        i_item_priority <= prio;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // remove fields carry random junk since the block must ignore them
    task automatic send_random(int insert_pct, int spread);
        if ($urandom_range(0, 99) < insert_pct)
            send_item(CMD_INSERT, pick_data(), pick_priority(spread));
        else
            send_item(CMD_REMOVE, $urandom, 8'($urandom));
    endtask

    // sender holds off until every owed result is in
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // removes on a fresh queue report empty with zeroed fields
    task automatic test_empty_remove();
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_REMOVE, 32'h0000_0000, 8'h00);
        wait_for_drain();
    endtask

    // extreme data and priorities, plus equal priorities leaving in order
    task automatic test_field_extremes();
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 8'hFF);
        send_item(CMD_INSERT, 32'h8000_0000, 8'h00);
        send_item(CMD_INSERT, 32'h0000_0000, 8'h80);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'h00);  // tie at the front
        send_item(CMD_INSERT, 32'h5555_AAAA, 8'hFF);  // tie at the tail
        send_item(CMD_INSERT, 32'hAAAA_5555, 8'h80);  // tie in the middle
        repeat (7)
            send_item(CMD_REMOVE, $urandom, 8'($urandom));
        wait_for_drain();
    endtask

    // fill to capacity, get refused, free a slot, refill it, get refused again, drain past empty
    task automatic test_full_queue();
        repeat (QUEUE_DEPTH)
            send_random(100, PRIO_NARROW);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 8'hFF);
        send_item(CMD_INSERT, 32'h8000_0000, 8'h00);
        send_item(CMD_REMOVE, $urandom, 8'($urandom));
        send_item(CMD_INSERT, pick_data(), 8'h00);
        send_item(CMD_INSERT, pick_data(), 8'h01);
        repeat (QUEUE_DEPTH + 2)
            send_item(CMD_REMOVE, $urandom, 8'($urandom));
        wait_for_drain();
    endtask

    // rounds that lean towards filling, draining or neither, so the queue
    // keeps crossing both ends; some rounds run with no gaps at all
    task automatic test_random_traffic();
        int insert_pct;
        int spread;
        for (int round = 0; round < 15; round++) begin
            case (round % 3)
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            spread  = $urandom_range(PRIO_NARROW, PRIO_BAND);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (40)
                send_random(insert_pct, spread);
            if (round == 7)
                wait_for_drain();
        end
        gaps_on = 1'b1;
        wait_for_drain();
    endtask

    initial begin
        // reset held low, then released
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_remove();
        test_field_extremes();
        test_full_queue();
        test_random_traffic();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
